[design/wdm_pkg.sv]
// package: field widths and the request and result codes of the watchdog monitor
package wdm_pkg;

    localparam int MODE_W  = 2;
    localparam int ID_W    = 4;
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 3;
    localparam int COUNT_W = 8;

    localparam logic [MODE_W-1:0] MODE_REGISTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHECKIN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SCAN     = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;

endpackage

[design/wdm_req_if.sv]
// interface: request channel into the watchdog monitor
interface wdm_req_if;
    logic                              valid;
    logic                              ready;
    logic [wdm_pkg::MODE_W-1:0]        mode;
    logic [wdm_pkg::ID_W-1:0]          task_id;
    logic [wdm_pkg::TIME_W-1:0]        timeout_ms;
    logic [wdm_pkg::TIME_W-1:0]        now_ms;

    modport source (output valid, output mode, output task_id, output timeout_ms,
                    output now_ms, input ready);
    modport sink   (input valid, input mode, input task_id, input timeout_ms,
                    input now_ms, output ready);
endinterface

[design/wdm_rsp_if.sv]
// interface: result channel out of the watchdog monitor
interface wdm_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [wdm_pkg::KIND_W-1:0]        kind;
    logic [wdm_pkg::SLOT_W-1:0]        slot_index;
    logic [wdm_pkg::COUNT_W-1:0]       restart_total;
    logic                              report;
    logic                              feed;
    logic                              last;

    modport source (output valid, output kind, output slot_index, output restart_total,
                    output report, output feed, output last, input ready);
    modport sink   (input valid, input kind, input slot_index, input restart_total,
                    input report, input feed, input last, output ready);
endinterface

[design/wdm_ram.sv]
// generic single-write, single-read ram with registered read data
module wdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/multi_task_watchdog_monitor.sv]
// top level: multi-task watchdog monitor with slot timeouts and check-in times in ram
//
//  channel   | dir | handshake      | payload
//  i_req     | in  | valid / ready  | mode, task_id, timeout_ms, now_ms
//  o_rsp     | out | valid / ready  | kind, slot_index, restart_total, report, feed, last
//  i_cfg_*   | in  | write enable   | report_enable
//
// register and check-in requests each give one acknowledge
// a scan checks each registered slot in S_READ then S_EVAL, skips free slots in S_READ,
// then gives the done result; S_EVAL uses the registered read data of the slot rams
// reset clears the registered marks, restart count and report enable; no clearing pass
// a full output register stalls the scan where a restart or done result is due
module multi_task_watchdog_monitor #(
    parameter int NUM_TASKS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wdm_req_if.sink       i_req,
    wdm_rsp_if.source     o_rsp,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata
);
    localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam int XW = (wdm_pkg::ID_W > CW) ? wdm_pkg::ID_W + 1 : CW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL
    } t_state;

    t_state                         r_state;
    logic [CW-1:0]                  r_idx;
    logic [wdm_pkg::TIME_W-1:0]     r_now;
    logic                           r_fail;
    logic [NUM_TASKS-1:0]           r_registered;
    logic [wdm_pkg::COUNT_W-1:0]    r_count;
    logic                           r_report_enable;

    logic                           r_out_valid;
    logic [wdm_pkg::KIND_W-1:0]     r_out_kind;
    logic [wdm_pkg::SLOT_W-1:0]     r_out_slot;
    logic [wdm_pkg::COUNT_W-1:0]    r_out_total;
    logic                           r_out_report;
    logic                           r_out_feed;
    logic                           r_out_last;

    logic                           out_free;
    logic                           accept;
    logic                           id_ok;
    logic                           slot_write;
    logic                           scan_end;
    logic [IW-1:0]                  idx_addr;
    logic [wdm_pkg::TIME_W-1:0]     tmo_rdata;
    logic [wdm_pkg::TIME_W-1:0]     ckin_rdata;
    logic [wdm_pkg::TIME_W-1:0]     elapsed;
    logic                           late;
    logic                           restart_fire;
    logic                           ckin_we;
    logic [IW-1:0]                  ckin_waddr;
    logic [wdm_pkg::TIME_W-1:0]     ckin_wdata;
    logic                           tmo_we;
    logic [IW-1:0]                  req_addr;

    assign out_free     = !r_out_valid || o_rsp.ready;
    assign i_req.ready  = (r_state == S_IDLE) && out_free;
    assign accept       = i_req.valid && i_req.ready;
    assign id_ok        = XW'(i_req.task_id) < XW'(NUM_TASKS);
    assign req_addr     = IW'(i_req.task_id);
    assign slot_write   = accept && id_ok &&
                          (i_req.mode == wdm_pkg::MODE_REGISTER ||
                           i_req.mode == wdm_pkg::MODE_CHECKIN);
    assign idx_addr     = r_idx[IW-1:0];
    assign scan_end     = r_idx == CW'(NUM_TASKS);
    assign elapsed      = r_now - ckin_rdata;
    assign late         = elapsed > tmo_rdata;
    assign restart_fire = (r_state == S_EVAL) && late && out_free;

    assign ckin_we      = slot_write || restart_fire;
    assign ckin_waddr   = restart_fire ? idx_addr : req_addr;
    assign ckin_wdata   = restart_fire ? r_now : i_req.now_ms;
    assign tmo_we       = slot_write && (i_req.mode == wdm_pkg::MODE_REGISTER);

    wdm_ram #(
        .WIDTH (wdm_pkg::TIME_W),
        .DEPTH (NUM_TASKS)
    ) u_tmo_ram (
        .i_clk   (i_clk),
        .i_we    (tmo_we),
        .i_waddr (req_addr),
        .i_wdata (i_req.timeout_ms),
        .i_raddr (idx_addr),
        .o_rdata (tmo_rdata)
    );

    wdm_ram #(
        .WIDTH (wdm_pkg::TIME_W),
        .DEPTH (NUM_TASKS)
    ) u_ckin_ram (
        .i_clk   (i_clk),
        .i_we    (ckin_we),
        .i_waddr (ckin_waddr),
        .i_wdata (ckin_wdata),
        .i_raddr (idx_addr),
        .o_rdata (ckin_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_idx           <= '0;
            r_fail          <= 1'b0;
            r_registered    <= '0;
            r_count         <= '0;
            r_report_enable <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_report_enable <= i_cfg_wdata;
            end
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_req.mode == wdm_pkg::MODE_SCAN) begin
                            r_state <= S_READ;
                            r_idx   <= '0;
                            r_now   <= i_req.now_ms;
                            r_fail  <= 1'b0;
                        end else begin
                            if (tmo_we) begin
                                r_registered[req_addr] <= 1'b1;
                            end
                            r_out_valid  <= 1'b1;
                            r_out_kind   <= wdm_pkg::KIND_ACK;
                            r_out_slot   <= '0;
                            r_out_total  <= r_count;
                            r_out_report <= 1'b0;
                            r_out_feed   <= 1'b0;
                            r_out_last   <= 1'b1;
                        end
                    end
                end
                S_READ: begin
                    if (scan_end) begin
                        if (out_free) begin
                            r_state      <= S_IDLE;
                            r_out_valid  <= 1'b1;
                            r_out_kind   <= wdm_pkg::KIND_DONE;
                            r_out_slot   <= '0;
                            r_out_total  <= r_count;
                            r_out_report <= 1'b0;
                            r_out_feed   <= !r_fail;
                            r_out_last   <= 1'b1;
                        end
                    end else if (r_registered[idx_addr]) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EVAL: begin
                    if (!late) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end else if (out_free) begin
                        r_idx        <= r_idx + 1'b1;
                        r_state      <= S_READ;
                        r_fail       <= 1'b1;
                        r_count      <= r_count + 1'b1;
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= wdm_pkg::KIND_RESTART;
                        r_out_slot   <= wdm_pkg::SLOT_W'(r_idx);
                        r_out_total  <= r_count + 1'b1;
                        r_out_report <= r_report_enable;
                        r_out_feed   <= 1'b0;
                        r_out_last   <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.kind          = r_out_kind;
    assign o_rsp.slot_index    = r_out_slot;
    assign o_rsp.restart_total = r_out_total;
    assign o_rsp.report        = r_out_report;
    assign o_rsp.feed          = r_out_feed;
    assign o_rsp.last          = r_out_last;
endmodule
